FILE: rtl/core/double_ended_queue_defines.svh
// Assertion macros for the deque core
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DUMP       = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_OUT,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic dump_start;
    logic dump_rd;
    logic dump_next;
    logic out_load;
    logic out_from_mem;
    res_e out_status;
    logic out_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
    logic out_free;
  } sts_t;

  // base + off modulo DEPTH; both operands are below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
    return (base == '0) ? IDX_W'(DEPTH - 1) : base - IDX_W'(1);
  endfunction

endpackage

FILE: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
module deq_ctrl import deq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_action_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  act_e   act;

  assign act = act_e'(in_action_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_status = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = ST_OVER;
              end else begin
                cmd_o.push_front = (act == ACT_PUSH_FRONT);
                cmd_o.push_back  = (act == ACT_PUSH_BACK);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_UNDER;
              end else begin
                cmd_o.pop_front = (act == ACT_POP_FRONT);
                cmd_o.pop_back  = (act == ACT_POP_BACK);
                state_d = S_POP_OUT;
              end
            end
            ACT_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d = S_DUMP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_OUT: begin
        // popped word arrives from the memory read register
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd_o.dump_rd = 1'b1;
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = sts_i.dump_last;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.dump_next = 1'b1;
            state_d = S_DUMP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/deq_dpath.sv
`timescale 1ns / 1ps
module deq_dpath import deq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [WORD_W-1:0] in_value_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               out_status_o,
  output logic signed [WORD_W-1:0] out_word_o,
  output logic                     out_last_o
);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_q;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] dump_idx_q, dump_idx_d;
  logic             out_valid_q, out_valid_d;
  res_e             out_status_q;
  logic signed [WORD_W-1:0] out_word_q;
  logic             out_last_q;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr, front_dec;

  assign front_dec = ring_dec(front_q);

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    dump_idx_d = dump_idx_q;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    rd_en      = 1'b0;
    rd_addr    = front_q;
    if (cmd_i.push_front) begin
      wr_en   = 1'b1;
      front_d = front_dec;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.push_back) begin
      wr_en   = 1'b1;
      wr_addr = ring_add(front_q, count_q);
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.pop_front) begin
      rd_en   = 1'b1;
      front_d = ring_add(front_q, CNT_W'(1));
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.pop_back) begin
      rd_en   = 1'b1;
      rd_addr = ring_add(front_q, count_q - CNT_W'(1));
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.dump_start) dump_idx_d = '0;
    if (cmd_i.dump_rd) begin
      rd_en   = 1'b1;
      rd_addr = ring_add(front_q, CNT_W'(dump_idx_q));
    end
    if (cmd_i.dump_next) dump_idx_d = dump_idx_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= in_value_i;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_word_q   <= cmd_i.out_from_mem ? rd_data_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q >= CNT_W'(DEPTH));
  assign sts_o.dump_last = ((CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q);
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_word_o   = out_word_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a 16-entry ring.
// Slave stream: tuser carries the action (push front, push back, pop front,
// pop back, dump), tdata the word to push. Master stream: tuser carries the
// status (ok, underflow, overflow, empty), tdata the popped or dumped word,
// tlast marks the final result word of an item.
// Push, refused push, empty pop, empty dump: one result word, valid on
// m_axis the cycle after the item is taken; the next item may follow at once.
// Unused action codes are taken and give no result.
// Pop: the word passes through the memory read register, then the output
// register, since the memory has a single registered read port; input is
// refused until it is loaded. Dump: one word per element, front to back,
// each read, then loaded into the output register; input waits for the last.
// The output register decouples the sides: an item is taken while a result is
// offered, as long as the sink takes it in that same cycle.
// Reset empties the queue; stored words are not cleared. A stalled sink holds
// the result word and stops the block until the word is taken.
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"
module double_ended_queue import deq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic signed [WORD_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic [2:0]               s_axis_tuser_i,  // [2:0] action
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic signed [WORD_W-1:0] m_axis_tdata_o,  // [31:0] word
  output logic [1:0]               m_axis_tuser_o,  // [1:0] status
  output logic                     m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_take;
  logic pop_take;
  logic out_stall;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  deq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_value_i   (s_axis_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_word_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;
  assign pop_take  = in_take && !sts.empty &&
                     (s_axis_tuser_i == ACT_POP_FRONT || s_axis_tuser_i == ACT_POP_BACK);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // never take a word while an untaken result would be overwritten
  `DEQ_ASSERT_SAME(a_no_overrun, in_take, !out_stall, "input taken over a stalled result")
  // a pop on a non-empty queue keeps the block busy the next cycle
  `DEQ_ASSERT_NEXT(a_pop_busy, pop_take, !s_axis_tready_o, "pop did not hold off input")
  // the queue is never both empty and full
  `DEQ_ASSERT_SAME(a_count_sane, 1'b1, !(sts.empty && sts.full), "queue both empty and full")

endmodule
